FILE: hdl/lfrs_pkg.sv
// Shared constants, types and position table builder for the log-frequency resampler.
package lfrs_pkg;

    // Build-time geometry
    localparam int ORIG_BINS = 129;
    localparam int NEW_BINS  = 256;
    localparam int COLUMNS   = 38;
    localparam int MAX_RUN   = 64;

    // Port widths
    localparam int LEVEL_W   = 16;
    localparam int LOG_BIN_W = 9;
    localparam int COLNUM_W  = 6;

    // Internal widths
    localparam int LOWER_W = $clog2(ORIG_BINS);
    localparam int FRAC_W  = 16;
    localparam int POS_W   = LOWER_W + FRAC_W;
    localparam int IDX_W   = $clog2(NEW_BINS);
    localparam int NLB_W   = $clog2(NEW_BINS + 1);
    localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RUN_W   = $clog2(MAX_RUN + 1);
    localparam int POS_DEN = (NEW_BINS > 1) ? (NEW_BINS - 1) : 1;

    typedef logic [POS_W-1:0] pos_t;
    typedef pos_t pos_tab_t [NEW_BINS];

    // ROM read request: two neighboring entries per cycle
    typedef struct packed {
        logic [IDX_W-1:0] addr_a;
        logic [IDX_W-1:0] addr_b;
    } rom_req_t;

    // Integer square root, 64-bit, bit-pair method (elaboration only)
    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        x    = x_in;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int s = 0; s < 32; s++) begin
            if (bitv > x) bitv = bitv >> 2;
        end
        for (int s = 0; s < 32; s++) begin
            if (bitv != 64'd0) begin
                if (x >= res + bitv) begin
                    x   = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // Log-spaced positions in Q16: integer part is the lower bin, low 16 bits the fraction
    function automatic pos_tab_t build_pos_tab();
        pos_tab_t    tab;
        logic [63:0] root [31];
        logic [63:0] n;
        logic [63:0] top;
        logic [63:0] e;
        logic [63:0] m;
        logic [63:0] lg;
        logic [63:0] prev;
        logic [63:0] t;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] y;
        logic [63:0] v;
        n    = 64'(ORIG_BINS - 1);
        top  = n << 16;
        e    = 64'd0;
        prev = 64'd0;
        root[0] = 64'd2 << 30;
        for (int k = 1; k <= 30; k++) begin
            root[k] = isqrt64(root[k-1] << 30);
        end
        for (int j = 0; j < 40; j++) begin
            if ((n >> (e + 64'd1)) != 64'd0) e = e + 64'd1;
        end
        m  = (n << 30) >> e;
        lg = e << 30;
        for (int k = 1; k <= 30; k++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m  = m >> 1;
                lg = lg | (64'd1 << (30 - k));
            end
        end
        for (int i = 0; i < NEW_BINS; i++) begin
            t = (lg * 64'(i)) / POS_DEN;
            q = t >> 30;
            r = t & ((64'd1 << 30) - 64'd1);
            y = 64'd1 << 30;
            for (int k = 1; k <= 30; k++) begin
                if (r[30-k]) y = (y * root[k]) >> 30;
            end
            if (q > 64'd20) q = 64'd20;
            v = ((y << q) + (64'd1 << 13)) >> 14;
            if (v > top) v = top;
            if (v < prev) v = prev;
            if (i == NEW_BINS - 1) v = top;
            tab[i] = v[POS_W-1:0];
            prev   = v;
        end
        return tab;
    endfunction

endpackage

FILE: hdl/lfrs_pos_rom.sv
// Dual-read synchronous ROM holding the log-spaced position table.
module lfrs_pos_rom
    import lfrs_pkg::*;
(
    input  logic     clk,
    input  rom_req_t req,
    output pos_t     pos_a,
    output pos_t     pos_b
);

    localparam pos_tab_t POS_TAB = build_pos_tab();

    pos_t pos_a_reg;
    pos_t pos_b_reg;

    // Registered reads on both ports
    always_ff @(posedge clk)
    begin
        pos_a_reg <= POS_TAB[req.addr_a];
        pos_b_reg <= POS_TAB[req.addr_b];
    end

    assign pos_a = pos_a_reg;
    assign pos_b = pos_b_reg;

endmodule

FILE: hdl/log_frequency_spectrum_resampler_unit.sv
// Log-frequency resampler top level: sequencer, interpolation datapath, output register.
// Each input bin passes through the idle (accept) state and a closing evaluate state, plus an
// evaluate and a turnaround state per result it produces (one ROM read turnaround per log bin).
// Results leave through a one-entry output register; the registered ROM read sets the turnaround.
// A new bin is taken only once the previous bin's run has been evaluated.
// Reset (rst_n low, asynchronous) clears all counters, the previous level and the output valid.
module log_frequency_spectrum_resampler_unit
    import lfrs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [LEVEL_W-1:0]   power_db,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [LEVEL_W-1:0]   level,
    output logic [LOG_BIN_W-1:0]        log_bin,
    output logic [COLNUM_W-1:0]         column_number,
    output logic                        run_last,
    output logic                        column_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_GAP  = 2'd2;

    localparam logic [LOWER_W-1:0] TOP_BIN = LOWER_W'(ORIG_BINS - 1);

    logic [1:0]                 state_reg, state_next;
    logic signed [LEVEL_W-1:0]  cur_reg;
    logic signed [LEVEL_W-1:0]  prev_level_reg, prev_level_next;
    logic [LOWER_W-1:0]         bin_cnt_reg, bin_cnt_next;
    logic [NLB_W-1:0]           nlb_reg, nlb_next;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [RUN_W-1:0]           run_cnt_reg, run_cnt_next;
    logic                       a_ok_reg, b_ok_reg;

    logic                       out_valid_reg, out_valid_next;
    logic signed [LEVEL_W-1:0]  level_reg;
    logic [LOG_BIN_W-1:0]       log_bin_reg;
    logic [COLNUM_W-1:0]        column_number_reg;
    logic                       run_last_reg;
    logic                       column_last_reg;

    rom_req_t                   rom_req;
    pos_t                       pos_a, pos_b;

    logic                       in_take;
    logic                       a_ok, b_ok;
    logic [NLB_W:0]             nlb_inc;
    logic [LOWER_W-1:0]         lower_a, lower_b, upper_a, upper_b;
    logic                       clamp_a, clamp_b;
    logic                       ready_a, ready_b;
    logic                       interp;
    logic signed [LEVEL_W:0]    diff;
    logic signed [2*LEVEL_W+1:0] prod;
    logic signed [2*LEVEL_W+1:0] rnd;
    logic signed [LEVEL_W-1:0]  lev;
    logic                       slot_free;
    logic                       emit;
    logic                       last_of_run;

    // Position ROM, read at the current log bin and the one after it
    assign nlb_inc = (NLB_W+1)'(nlb_reg) + (NLB_W+1)'(1);
    assign a_ok    = nlb_reg < NLB_W'(NEW_BINS);
    assign b_ok    = nlb_inc < (NLB_W+1)'(NEW_BINS);
    assign rom_req.addr_a = a_ok ? nlb_reg[IDX_W-1:0] : '0;
    assign rom_req.addr_b = b_ok ? nlb_inc[IDX_W-1:0] : '0;

    lfrs_pos_rom u_pos_rom (
        .clk   (clk),
        .req   (rom_req),
        .pos_a (pos_a),
        .pos_b (pos_b)
    );

    // Neighbor bins and readiness of the two fetched positions
    assign lower_a = pos_a[POS_W-1:FRAC_W];
    assign lower_b = pos_b[POS_W-1:FRAC_W];
    assign clamp_a = lower_a >= TOP_BIN;
    assign clamp_b = lower_b >= TOP_BIN;
    assign upper_a = clamp_a ? TOP_BIN : lower_a + LOWER_W'(1);
    assign upper_b = clamp_b ? TOP_BIN : lower_b + LOWER_W'(1);
    assign ready_a = a_ok_reg && (upper_a <= bin_cnt_reg);
    assign ready_b = b_ok_reg && (upper_b <= bin_cnt_reg);

    // Interpolation lo + round(f * (hi - lo)), else the current level; the result stays between lo and hi
    assign interp = !clamp_a && (lower_a + LOWER_W'(1) == bin_cnt_reg);
    assign diff   = (LEVEL_W+1)'(cur_reg) - (LEVEL_W+1)'(prev_level_reg);
    assign prod   = $signed({1'b0, pos_a[FRAC_W-1:0]}) * diff;
    assign rnd    = (prod + (2*LEVEL_W+2)'(32768)) >>> FRAC_W;
    assign lev    = interp ? prev_level_reg + rnd[LEVEL_W-1:0] : cur_reg;

    // Sequencer decisions
    assign in_take     = in_valid && !in_stall;
    assign slot_free   = !out_valid_reg || !out_stall;
    assign emit        = (state_reg == S_EVAL) && ready_a &&
                         (run_cnt_reg != RUN_W'(MAX_RUN)) && slot_free;
    assign last_of_run = (run_cnt_reg == RUN_W'(MAX_RUN - 1)) || !ready_b;

    always_comb
    begin
        state_next      = state_reg;
        prev_level_next = prev_level_reg;
        bin_cnt_next    = bin_cnt_reg;
        nlb_next        = nlb_reg;
        col_next        = col_reg;
        run_cnt_next    = run_cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take) begin
                    run_cnt_next = '0;
                    state_next   = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!ready_a) begin
                    // Run done: commit the bin and close the column on the top bin
                    prev_level_next = cur_reg;
                    state_next      = S_IDLE;
                    if (bin_cnt_reg == TOP_BIN) begin
                        bin_cnt_next = '0;
                        nlb_next     = '0;
                        col_next     = (col_reg == COL_W'(COLUMNS - 1)) ? '0
                                                                         : col_reg + COL_W'(1);
                    end else begin
                        bin_cnt_next = bin_cnt_reg + LOWER_W'(1);
                    end
                end else if (run_cnt_reg == RUN_W'(MAX_RUN)) begin
                    // Overflowing run: skip without output
                    nlb_next   = nlb_reg + NLB_W'(1);
                    state_next = S_GAP;
                end else if (slot_free) begin
                    run_cnt_next = run_cnt_reg + RUN_W'(1);
                    nlb_next     = nlb_reg + NLB_W'(1);
                    state_next   = S_GAP;
                end
            end
            S_GAP:
            begin
                // ROM turnaround after the log bin advanced
                state_next = S_EVAL;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            prev_level_reg <= '0;
            bin_cnt_reg    <= '0;
            nlb_reg        <= '0;
            col_reg        <= '0;
            run_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            prev_level_reg <= prev_level_next;
            bin_cnt_reg    <= bin_cnt_next;
            nlb_reg        <= nlb_next;
            col_reg        <= col_next;
            run_cnt_reg    <= run_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Output valid: set on a new result, cleared when the transaction completes
    always_comb
    begin
        priority if (emit) begin
            out_valid_next = 1'b1;
        end else if (!out_stall) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_ok_reg <= a_ok;
        b_ok_reg <= b_ok;
        if (in_take) begin
            cur_reg <= power_db;
        end
        if (emit) begin
            level_reg         <= lev;
            log_bin_reg       <= LOG_BIN_W'(nlb_reg);
            column_number_reg <= COLNUM_W'(col_reg);
            run_last_reg      <= last_of_run;
            column_last_reg   <= nlb_reg == NLB_W'(NEW_BINS - 1);
        end
    end

    assign in_stall      = state_reg != S_IDLE;
    assign out_valid     = out_valid_reg;
    assign level         = level_reg;
    assign log_bin       = log_bin_reg;
    assign column_number = column_number_reg;
    assign run_last      = run_last_reg;
    assign column_last   = column_last_reg;

    // Counters stay in range
    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        bin_cnt_reg <= TOP_BIN)
        else $error("bin counter out of range");

    a_nlb_range: assert property (@(posedge clk) disable iff (!rst_n)
        nlb_reg <= NLB_W'(NEW_BINS))
        else $error("log bin counter out of range");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(COLUMNS - 1))
        else $error("column counter out of range");

    // Every result is followed by the ROM turnaround state
    a_emit_gap: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (state_reg == S_GAP))
        else $error("result not followed by turnaround");

    // A held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !emit)
        else $error("pending result overwritten");

endmodule

FILE: test/log_frequency_spectrum_resampler_unit_tb.sv
// Testbench for the log-frequency resampler: table-driven and random columns against a bit-exact predictor.
`timescale 1ns / 1ps

module log_frequency_spectrum_resampler_unit_tb;
    import lfrs_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int          RANDOM_ITEMS = 150;
    localparam int          HOLD_CYCLES  = 600;
    localparam int          HOLD_AT_ITEM = 40;
    localparam int          MODE_B_START = 93;
    localparam int          MODE_C_START = 186;
    localparam int          DIR_ROWS     = 13;
    localparam int          DRAIN_CYCLES = 40;

    // One resampled output value as seen on the result port
    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic [LOG_BIN_W-1:0]      log_bin;
        logic [COLNUM_W-1:0]       column;
        logic                      run_last;
        logic                      column_last;
    } resample_t;

    // Directed row: a bin value repeated count times, optionally with a known level
    typedef struct packed {
        logic [LEVEL_W-1:0] value;
        int                 count;
        logic               typed;
        logic [LEVEL_W-1:0] typed_level;
    } dir_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [LEVEL_W-1:0] power_db = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [LEVEL_W-1:0] level;
    logic [LOG_BIN_W-1:0]      log_bin;
    logic [COLNUM_W-1:0]       column_number;
    logic                      run_last;
    logic                      column_last;

    // Predictor state
    int unsigned        position_q16 [NEW_BINS];
    logic [LEVEL_W-1:0] last_power;
    int                 bin_index;
    int                 log_cursor;
    int                 column_index;
    resample_t          pending_results [$];

    int          mismatch_count = 0;
    int          items_sent = 0;
    int          send_idle_pct = 34;
    int          recv_idle_pct = 79;
    bit          hold_req = 1'b0;
    logic        hold_active = 1'b0;
    int unsigned cycle_count = 0;
    resample_t   got_result;
    resample_t   want_result;
    dir_row_t    directed_rows [DIR_ROWS];

    log_frequency_spectrum_resampler_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .power_db      (power_db),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .level         (level),
        .log_bin       (log_bin),
        .column_number (column_number),
        .run_last      (run_last),
        .column_last   (column_last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Floor of the square root, two bits per step
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] acc;
        logic [63:0] probe;
        x     = x_in;
        acc   = 64'd0;
        probe = 64'd1 << 62;
        while (probe > x) probe = probe >> 2;
        while (probe != 64'd0)
        begin
            if (x >= acc + probe)
            begin
                x   = x - (acc + probe);
                acc = (acc >> 1) + probe;
            end
            else
            begin
                acc = acc >> 1;
            end
            probe = probe >> 2;
        end
        return acc;
    endfunction

    // Log-spaced positions in Q16, integer-only exponent evaluation
    task automatic build_positions();
        logic [63:0] roots [31];
        logic [63:0] span;
        logic [63:0] top_q16;
        logic [63:0] den;
        logic [63:0] expo;
        logic [63:0] mant;
        logic [63:0] log_q30;
        logic [63:0] prev_v;
        logic [63:0] t;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] y;
        logic [63:0] v;
        span     = 64'(ORIG_BINS - 1);
        top_q16  = span << 16;
        den      = (NEW_BINS > 1) ? 64'(NEW_BINS - 1) : 64'd1;
        roots[0] = 64'd2 << 30;
        for (int k = 1; k <= 30; k++) roots[k] = floor_sqrt(roots[k-1] << 30);
        expo = 64'd0;
        while (expo < 64'd40 && (span >> (expo + 64'd1)) != 64'd0) expo = expo + 64'd1;
        // log2 of the span: integer part from the MSB, fraction by squaring
        mant    = (span << 30) >> expo;
        log_q30 = expo << 30;
        for (int k = 1; k <= 30; k++)
        begin
            mant = (mant * mant) >> 30;
            if (mant >= (64'd2 << 30))
            begin
                mant    = mant >> 1;
                log_q30 = log_q30 | (64'd1 << (30 - k));
            end
        end
        prev_v = 64'd0;
        for (int i = 0; i < NEW_BINS; i++)
        begin
            t = (log_q30 * 64'(i)) / den;
            q = t >> 30;
            r = t & ((64'd1 << 30) - 64'd1);
            y = 64'd1 << 30;
            for (int k = 1; k <= 30; k++)
                if (r[30-k]) y = (y * roots[k]) >> 30;
            if (q > 64'd20) q = 64'd20;
            v = ((y << q) + (64'd1 << 13)) >> 14;
            if (v > top_q16) v = top_q16;
            if (v < prev_v) v = prev_v;
            if (i == NEW_BINS - 1) v = top_q16;
            position_q16[i] = v[31:0];
            prev_v = v;
        end
    endtask

    // Expected run of interpolated values for one accepted bin
    task automatic predict_bin(input logic [LEVEL_W-1:0] raw, input logic typed,
                               input logic [LEVEL_W-1:0] typed_level);
        longint    cur;
        longint    prv;
        longint    lev;
        int        lower;
        int        upper;
        int        frac;
        int        emitted;
        bit        clamp;
        bit        held_valid;
        resample_t held;
        cur        = longint'($signed(raw));
        prv        = longint'($signed(last_power));
        emitted    = 0;
        held_valid = 1'b0;
        held       = '0;
        while (log_cursor < NEW_BINS)
        begin
            lower = int'(position_q16[log_cursor] >> 16);
            frac  = int'(position_q16[log_cursor] & 32'hFFFF);
            clamp = (lower >= ORIG_BINS - 1);
            upper = clamp ? ORIG_BINS - 1 : lower + 1;
            if (upper > bin_index) break;
            // overlong runs drop their tail silently
            if (emitted < MAX_RUN)
            begin
                if (clamp || lower + 1 != bin_index) lev = cur;
                else lev = prv + ((longint'(frac) * (cur - prv) + 64'sd32768) >>> 16);
                if (held_valid) pending_results.push_back(held);
                held.level       = typed ? typed_level : lev[LEVEL_W-1:0];
                held.log_bin     = LOG_BIN_W'(log_cursor);
                held.column      = COLNUM_W'(column_index);
                held.run_last    = 1'b0;
                held.column_last = (log_cursor == NEW_BINS - 1);
                held_valid       = 1'b1;
                emitted++;
            end
            log_cursor++;
        end
        if (held_valid)
        begin
            held.run_last = 1'b1;
            pending_results.push_back(held);
        end
        last_power = raw;
        // column end
        if (bin_index >= ORIG_BINS - 1)
        begin
            bin_index    = 0;
            log_cursor   = 0;
            column_index = (column_index + 1) % COLUMNS;
        end
        else
        begin
            bin_index++;
        end
    endtask

    // Offer one bin, idling first as the current mode says, and predict on acceptance
    task automatic offer_bin(input logic [LEVEL_W-1:0] value, input logic typed,
                             input logic [LEVEL_W-1:0] typed_level);
        if (items_sent < MODE_B_START)
        begin
            send_idle_pct  = 34;
            recv_idle_pct <= 79;
        end
        else if (items_sent < MODE_C_START)
        begin
            send_idle_pct  = 79;
            recv_idle_pct <= 34;
        end
        else
        begin
            send_idle_pct  = 0;
            recv_idle_pct <= 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        power_db <= value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_bin(value, typed, typed_level);
        items_sent++;
    endtask

    // Long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Result side: check every transaction, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_result = {level, log_bin, column_number, run_last, column_last};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: level %0d log_bin %0d column %0d",
                             $signed(level), log_bin, column_number);
            end
            else
            begin
                want_result = pending_results.pop_front();
                if (got_result !== want_result)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected level %0d bin %0d col %0d rl %0b cl %0b, %s",
                                 $signed(want_result.level), want_result.log_bin,
                                 want_result.column, want_result.run_last,
                                 want_result.column_last, "got:");
                    if (mismatch_count <= 10)
                        $display("          actual   level %0d bin %0d col %0d rl %0b cl %0b",
                                 $signed(level), log_bin, column_number, run_last, column_last);
                end
            end
        end
        out_stall <= hold_active || ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL log_frequency_spectrum_resampler_unit");
            $finish;
        end
    end

    initial
    begin
        logic [LEVEL_W-1:0] value;
        // Column 0: extremes, full-scale swings, bit toggles, top clamp on the last bin
        directed_rows[0]  = '{16'h7FFF, 3, 1'b1, 16'h7FFF};
        directed_rows[1]  = '{16'h8000, 1, 1'b0, 16'h0000};
        directed_rows[2]  = '{16'h8000, 2, 1'b1, 16'h8000};
        directed_rows[3]  = '{16'h7FFF, 1, 1'b0, 16'h0000};
        directed_rows[4]  = '{16'h0000, 1, 1'b0, 16'h0000};
        directed_rows[5]  = '{16'hFFFF, 1, 1'b0, 16'h0000};
        directed_rows[6]  = '{16'h0001, 1, 1'b0, 16'h0000};
        directed_rows[7]  = '{16'h8001, 1, 1'b0, 16'h0000};
        directed_rows[8]  = '{16'h7FFE, 1, 1'b0, 16'h0000};
        directed_rows[9]  = '{16'h5555, 1, 1'b0, 16'h0000};
        directed_rows[10] = '{16'hAAAA, 1, 1'b0, 16'h0000};
        directed_rows[11] = '{16'h1234, 114, 1'b0, 16'h0000};
        directed_rows[12] = '{16'h4321, 1, 1'b0, 16'h0000};

        build_positions();
        last_power   = '0;
        bin_index    = 0;
        log_cursor   = 0;
        column_index = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
            for (int c = 0; c < directed_rows[r].count; c++)
                offer_bin(directed_rows[r].value, directed_rows[r].typed,
                          directed_rows[r].typed_level);

        // Random bins: full range, near zero, rail values and slow drift
        value = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == HOLD_AT_ITEM) hold_req = 1'b1;
            case ($urandom_range(3))
                0: value = LEVEL_W'($urandom);
                1: value = LEVEL_W'($urandom_range(511)) - 16'd256;
                2:
                begin
                    case ($urandom_range(3))
                        0: value = 16'h7FFF;
                        1: value = 16'h8000;
                        2: value = 16'h0000;
                        default: value = 16'hFFFF;
                    endcase
                end
                default: value = value + LEVEL_W'($urandom_range(2047)) - 16'd1024;
            endcase
            offer_bin(value, 1'b0, 16'h0000);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS log_frequency_spectrum_resampler_unit");
        else
            $display("FAIL log_frequency_spectrum_resampler_unit");
        $finish;
    end

endmodule

FILE: files.f
hdl/lfrs_pkg.sv
hdl/lfrs_pos_rom.sv
hdl/log_frequency_spectrum_resampler_unit.sv
test/log_frequency_spectrum_resampler_unit_tb.sv
